/* rtl/ate_pkg.sv */
package ate_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ONE,
    ST_SORT,
    ST_WALK
  } state_t;

  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_DELETE  = 3'd1;
  localparam logic [2:0] OP_SEARCH  = 3'd2;
  localparam logic [2:0] OP_SORT    = 3'd3;
  localparam logic [2:0] OP_DISPLAY = 3'd4;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_FULL     = 3'd1;
  localparam logic [2:0] STAT_EMPTY    = 3'd2;
  localparam logic [2:0] STAT_NOTFOUND = 3'd3;
  localparam logic [2:0] STAT_BADOP    = 3'd4;

  // Longest run of results that one listing produces.
  localparam int LIST_MAX = 64;

  typedef struct packed {
    logic load;
    logic shift;
    logic lo_swap;
    logic hi_swap;
  } cell_ctl_t;

endpackage

/* rtl/ate_if.sv */
interface ate_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [31:0] value;
  logic [5:0]         index;

  modport source (output valid, opcode, value, index, input ready);
  modport sink   (input valid, opcode, value, index, output ready);
endinterface

interface ate_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [5:0]         position;
  logic signed [31:0] element;
  logic [6:0]         count;
  logic               last;

  modport source (output valid, status, position, element, count, last, input ready);
  modport sink   (input valid, status, position, element, count, last, output ready);
endinterface

/* rtl/ate_cell.sv */
module ate_cell
  import ate_pkg::*;
(
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic signed [31:0] wdata,
  input  logic signed [31:0] next_val,
  input  logic signed [31:0] prev_val,
  output logic signed [31:0] val
);

  logic signed [31:0] val_r;
  logic signed [31:0] val_nxt;

  // A cell loads, shifts, or acts as the lower or the upper half of a compare-exchange pair.
  always_comb begin
    val_nxt = val_r;
    if (ctl.load) begin
      val_nxt = wdata;
    end else if (ctl.shift) begin
      val_nxt = next_val;
    end else if (ctl.lo_swap && (val_r > next_val)) begin
      val_nxt = next_val;
    end else if (ctl.hi_swap && (prev_val > val_r)) begin
      val_nxt = prev_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

/* rtl/array_table_engine.sv */
// Insert, delete and bad opcodes: handled in ST_ONE, result registered when the output can take it.
// Search: a full ring walk, then the result from ST_ONE; display: a ring walk,
// one result per cycle unless the output stalls. Sort: DEPTH odd-even passes,
// then a full ring walk. The ring of cells rotates once per walk.
// Reset clears the entry count and control; entry values are not cleared.
module array_table_engine
  import ate_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  ate_in_if.sink      in_chan,
  ate_out_if.source   out_chan
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int CX = (CW > 7) ? CW : 7;
  localparam int KX = (IW > 6) ? IW : 6;

  state_t             state_r, state_nxt;
  logic [2:0]         op_r;
  logic signed [31:0] val_r;
  logic [5:0]         idx_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic [IW-1:0]      k_r;
  logic               found_r;
  logic [5:0]         fpos_r;

  logic               out_valid_r;
  logic [2:0]         status_r;
  logic [5:0]         position_r;
  logic signed [31:0] element_r;
  logic [6:0]         ocount_r;
  logic               last_r;

  logic signed [31:0] cell_val [DEPTH];
  cell_ctl_t          cell_ctl [DEPTH];

  logic               accept;
  logic               can_emit;
  logic [CX-1:0]      count_x;
  logic [CX-1:0]      lim_x;
  logic [CX-1:0]      k_x;
  logic [KX-1:0]      k_ext;
  logic               full;
  logic               del_ok;
  logic               list_op;
  logic               walk_emit;
  logic               walk_go;
  logic               walk_end;
  logic               match;
  logic               load_go;
  logic               del_go;
  logic               emit;
  logic [2:0]         e_status;
  logic [5:0]         e_position;
  logic signed [31:0] e_element;
  logic               e_last;

  assign accept   = in_chan.valid && in_chan.ready;
  assign can_emit = !out_valid_r || out_chan.ready;
  assign count_x  = CX'(count_r);
  assign lim_x    = (count_x > CX'(LIST_MAX)) ? CX'(LIST_MAX) : count_x;
  assign k_x      = CX'(k_r);
  assign k_ext    = KX'(k_r);
  assign full     = (count_r == CW'(DEPTH));
  assign del_ok   = (CX'(idx_r) < count_x);
  assign list_op  = (op_r == OP_SORT) || (op_r == OP_DISPLAY);
  assign walk_end = (k_r == IW'(DEPTH - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_chan.opcode == OP_SEARCH) begin
            state_nxt = ST_WALK;
          end else if ((in_chan.opcode == OP_SORT) && (count_r != '0)) begin
            state_nxt = ST_SORT;
          end else if ((in_chan.opcode == OP_DISPLAY) && (count_r != '0)) begin
            state_nxt = ST_WALK;
          end else begin
            state_nxt = ST_ONE;
          end
        end
      end
      ST_ONE: begin
        if (can_emit) state_nxt = ST_IDLE;
      end
      ST_SORT: begin
        if (walk_end) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (walk_go && walk_end) begin
          state_nxt = (op_r == OP_SEARCH) ? ST_ONE : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready = (state_r == ST_IDLE);
    walk_emit  = list_op && (k_x < lim_x);
    walk_go    = (state_r == ST_WALK) && (!walk_emit || can_emit);
    match      = (op_r == OP_SEARCH) && (k_x < count_x) && !found_r && (cell_val[0] == val_r);
    load_go    = (state_r == ST_ONE) && (op_r == OP_INSERT) && !full && can_emit;
    del_go     = (state_r == ST_ONE) && (op_r == OP_DELETE) && del_ok && can_emit;
    emit       = 1'b0;
    e_status   = STAT_OK;
    e_position = '0;
    e_element  = '0;
    e_last     = 1'b1;
    count_nxt  = count_r;
    if (state_r == ST_ONE) begin
      emit = can_emit;
      case (op_r) inside
        OP_INSERT: begin
          e_status = full ? STAT_FULL : STAT_OK;
          if (!full && can_emit) count_nxt = count_r + 1'b1;
        end
        OP_DELETE: begin
          e_status = del_ok ? STAT_OK : STAT_EMPTY;
          if (del_ok && can_emit) count_nxt = count_r - 1'b1;
        end
        OP_SEARCH: begin
          e_status   = found_r ? STAT_OK : STAT_NOTFOUND;
          e_position = found_r ? fpos_r : 6'd0;
        end
        OP_SORT, OP_DISPLAY: e_status = STAT_EMPTY;
        default: e_status = STAT_BADOP;
      endcase
    end else if (state_r == ST_WALK) begin
      emit       = walk_emit && can_emit;
      e_position = k_ext[5:0];
      e_element  = cell_val[0];
      e_last     = ((k_x + 1'b1) == lim_x);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_comb begin
      cell_ctl[i].load    = load_go && (count_r == CW'(i));
      cell_ctl[i].shift   = walk_go || (del_go && (CX'(idx_r) <= CX'(i)));
      cell_ctl[i].lo_swap = (state_r == ST_SORT) && (k_r[0] == 1'(i % 2))
                            && (CX'(i + 1) < count_x);
      cell_ctl[i].hi_swap = (state_r == ST_SORT) && (i >= 1)
                            && (k_r[0] == 1'((i + 1) % 2)) && (CX'(i) < count_x);
    end

    ate_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl[i]),
      .wdata    (val_r),
      .next_val (cell_val[(i + 1) % DEPTH]),
      .prev_val (cell_val[(i + DEPTH - 1) % DEPTH]),
      .val      (cell_val[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        k_r     <= '0;
        found_r <= 1'b0;
      end else if (state_r == ST_SORT) begin
        k_r <= walk_end ? '0 : k_r + 1'b1;
      end else if (walk_go) begin
        k_r <= k_r + 1'b1;
        if (match) found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_chan.opcode;
      val_r <= in_chan.value;
      idx_r <= in_chan.index;
    end
    if (walk_go && match) fpos_r <= k_ext[5:0];
    if (emit) begin
      status_r   <= e_status;
      position_r <= e_position;
      element_r  <= e_element;
      ocount_r   <= 7'(CX'(count_nxt));
      last_r     <= e_last;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.status   = status_r;
  assign out_chan.position = position_r;
  assign out_chan.element  = element_r;
  assign out_chan.count    = ocount_r;
  assign out_chan.last     = last_r;

endmodule

/* bench/ate_tb_if.sv */
`timescale 1ns / 100ps
// The channel interfaces come with the RTL in rtl/ate_if.sv; this file holds the
// stimulus row type shared by the bench.
package ate_tb_pkg;
  import ate_pkg::*;

  typedef struct {
    logic [2:0]         opcode;
    logic signed [31:0] value;
    logic [5:0]         index;
    bit                 typed;     // expected result given in the row
    logic [2:0]         status;
    logic [6:0]         count;
  } stim_row_t;
endpackage

/* bench/array_table_engine_tb.sv */
`timescale 1ns / 100ps
module array_table_engine_tb;
  import ate_pkg::*;
  import ate_tb_pkg::*;

  localparam int DEPTH = 64;

  typedef struct {
    logic [2:0]         status;
    logic [5:0]         position;
    logic signed [31:0] element;
    logic [6:0]         count;
    logic               last;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ate_in_if  in_chan();
  ate_out_if out_chan();

  array_table_engine #(.DEPTH(DEPTH)) uut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the table.
  logic signed [31:0] shadow_entries [DEPTH];
  int                 shadow_count;
  table_result_t      pending_results [$];
  int                 mismatch_count;
  int                 result_count;
  int                 item_count;
  bit                 stall_enable;

  function automatic table_result_t make_result(logic [2:0] st, int pos,
                                                logic signed [31:0] el, logic lst);
    table_result_t r;
    r.status   = st;
    r.position = pos[5:0];
    r.element  = el;
    r.count    = shadow_count[6:0];
    r.last     = lst;
    return r;
  endfunction

  task automatic list_entries();
    int n;
    n = (shadow_count > LIST_MAX) ? LIST_MAX : shadow_count;
    if (n == 0) begin
      pending_results.push_back(make_result(STAT_EMPTY, 0, 0, 1'b1));
    end else begin
      for (int i = 0; i < n; i++)
        pending_results.push_back(make_result(STAT_OK, i, shadow_entries[i], i == n - 1));
    end
  endtask

  task automatic apply_request(logic [2:0] op, logic signed [31:0] val, logic [5:0] idx);
    bit hit;
    logic signed [31:0] t;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= DEPTH) begin
          pending_results.push_back(make_result(STAT_FULL, 0, 0, 1'b1));
        end else begin
          shadow_entries[shadow_count] = val;
          shadow_count++;
          pending_results.push_back(make_result(STAT_OK, 0, 0, 1'b1));
        end
      end
      OP_DELETE: begin
        if (shadow_count == 0 || idx >= shadow_count) begin
          pending_results.push_back(make_result(STAT_EMPTY, 0, 0, 1'b1));
        end else begin
          for (int j = idx; j + 1 < shadow_count; j++)
            shadow_entries[j] = shadow_entries[j + 1];
          shadow_count--;
          pending_results.push_back(make_result(STAT_OK, 0, 0, 1'b1));
        end
      end
      OP_SEARCH: begin
        hit = 1'b0;
        for (int i = 0; i < shadow_count && !hit; i++) begin
          if (shadow_entries[i] == val) begin
            hit = 1'b1;
            pending_results.push_back(make_result(STAT_OK, i, 0, 1'b1));
          end
        end
        if (!hit)
          pending_results.push_back(make_result(STAT_NOTFOUND, 0, 0, 1'b1));
      end
      OP_SORT: begin
        for (int i = 0; i < shadow_count; i++)
          for (int j = i + 1; j < shadow_count; j++)
            if (shadow_entries[i] > shadow_entries[j]) begin
              t = shadow_entries[i];
              shadow_entries[i] = shadow_entries[j];
              shadow_entries[j] = t;
            end
        list_entries();
      end
      OP_DISPLAY: list_entries();
      default: pending_results.push_back(make_result(STAT_BADOP, 0, 0, 1'b1));
    endcase
  endtask

  // Result checker, sampled at the rising edge.
  always @(posedge clk) begin
    table_result_t exp_r;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result status=%0d pos=%0d elem=%0d count=%0d last=%0d",
                   out_chan.status, out_chan.position, out_chan.element,
                   out_chan.count, out_chan.last);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_chan.status !== exp_r.status || out_chan.position !== exp_r.position ||
            out_chan.element !== exp_r.element || out_chan.count !== exp_r.count ||
            out_chan.last !== exp_r.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"ERROR: result %0d expected st=%0d pos=%0d el=%0d cnt=%0d last=%0d,",
                      " got st=%0d pos=%0d el=%0d cnt=%0d last=%0d"},
                     result_count, exp_r.status, exp_r.position, exp_r.element,
                     exp_r.count, exp_r.last, out_chan.status, out_chan.position,
                     out_chan.element, out_chan.count, out_chan.last);
        end
      end
    end
  end

  // Receiver stalls: a short repeating pattern, switched on and off in phases.
  logic [6:0] stall_pattern = 7'b1011001;
  always @(negedge clk) begin
    stall_pattern <= {stall_pattern[5:0], stall_pattern[6]};
    out_chan.ready <= stall_enable ? stall_pattern[0] : 1'b1;
  end

  task automatic send_item(logic [2:0] op, logic signed [31:0] val, logic [5:0] idx,
                           bit typed, logic [2:0] st, logic [6:0] cnt);
    table_result_t hold;
    in_chan.valid  <= 1'b1;
    in_chan.opcode <= op;
    in_chan.value  <= val;
    in_chan.index  <= idx;
    do @(posedge clk); while (!in_chan.ready);
    apply_request(op, val, idx);
    item_count++;
    if (typed) begin
      hold = pending_results[pending_results.size() - 1];
      if (hold.status !== st || hold.count !== cnt) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: table row op=%0d predicts st=%0d cnt=%0d, row says st=%0d cnt=%0d",
                   op, hold.status, hold.count, st, cnt);
      end
    end
    @(negedge clk);
    in_chan.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Keeps valid high across back-to-back items within a burst.
  task automatic send_burst_item(logic [2:0] op, logic signed [31:0] val, logic [5:0] idx,
                                 bit keep);
    in_chan.valid  <= 1'b1;
    in_chan.opcode <= op;
    in_chan.value  <= val;
    in_chan.index  <= idx;
    do @(posedge clk); while (!in_chan.ready);
    apply_request(op, val, idx);
    item_count++;
    @(negedge clk);
    if (!keep) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2 * DEPTH + 8) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_value(int pool);
    case ($urandom_range(0, 5))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return $urandom;
      default: return $signed($urandom_range(0, pool)) - (pool / 2);
    endcase
  endfunction

  stim_row_t directed_rows [$];

  task automatic add_row(logic [2:0] op, logic signed [31:0] val, logic [5:0] idx,
                         bit typed, logic [2:0] st, logic [6:0] cnt);
    stim_row_t r;
    r.opcode = op; r.value = val; r.index = idx;
    r.typed = typed; r.status = st; r.count = cnt;
    directed_rows.push_back(r);
  endtask

  initial begin
    logic [2:0] op;
    int burst_len;
    int n_random;
    in_chan.valid  = 1'b0;
    in_chan.opcode = OP_INSERT;
    in_chan.value  = '0;
    in_chan.index  = '0;
    out_chan.ready = 1'b1;
    stall_enable   = 1'b0;
    shadow_count   = 0;
    mismatch_count = 0;
    result_count   = 0;
    item_count     = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty-table cases, extremes and every opcode.
    add_row(OP_DISPLAY, 0, 0, 1, STAT_EMPTY, 0);
    add_row(OP_SORT, 0, 0, 1, STAT_EMPTY, 0);
    add_row(OP_DELETE, 0, 0, 1, STAT_EMPTY, 0);
    add_row(OP_SEARCH, 5, 0, 1, STAT_NOTFOUND, 0);
    add_row(3'd5, 0, 0, 1, STAT_BADOP, 0);
    add_row(3'd6, -1, 63, 1, STAT_BADOP, 0);
    add_row(3'd7, 32'sh7fff_ffff, 0, 1, STAT_BADOP, 0);
    add_row(OP_INSERT, 32'sh7fff_ffff, 0, 1, STAT_OK, 1);
    add_row(OP_INSERT, 32'sh8000_0000, 0, 1, STAT_OK, 2);
    add_row(OP_INSERT, -1, 0, 1, STAT_OK, 3);
    add_row(OP_INSERT, 0, 0, 1, STAT_OK, 4);
    add_row(OP_INSERT, -1, 0, 1, STAT_OK, 5);
    add_row(OP_SEARCH, -1, 0, 0, 0, 0);
    add_row(OP_SEARCH, 32'sh8000_0000, 0, 0, 0, 0);
    add_row(OP_DISPLAY, 0, 0, 0, 0, 0);
    add_row(OP_DELETE, 0, 63, 1, STAT_EMPTY, 5);
    add_row(OP_DELETE, 0, 5, 1, STAT_EMPTY, 5);
    add_row(OP_DELETE, 0, 1, 1, STAT_OK, 4);
    add_row(OP_SORT, 0, 0, 0, 0, 0);
    add_row(OP_DELETE, 0, 3, 1, STAT_OK, 3);
    add_row(OP_SEARCH, 32'sh7fff_ffff, 0, 1, STAT_NOTFOUND, 3);
    add_row(OP_DISPLAY, 0, 0, 0, 0, 0);
    foreach (directed_rows[i])
      send_item(directed_rows[i].opcode, directed_rows[i].value, directed_rows[i].index,
                directed_rows[i].typed, directed_rows[i].status, directed_rows[i].count);
    wait_drained();

    // Fill to full with stalls, then hit the full and listing-maximum cases.
    stall_enable = 1'b1;
    while (shadow_count < DEPTH)
      send_burst_item(OP_INSERT, rand_value(40), 0, shadow_count < DEPTH - 1);
    send_item(OP_INSERT, 1, 0, 1, STAT_FULL, 7'd64);
    send_item(OP_SORT, 0, 0, 0, 0, 0);
    send_item(OP_DELETE, 0, 63, 1, STAT_OK, 7'd63);
    send_item(OP_DISPLAY, 0, 0, 0, 0, 0);
    // Sender pause until every expected transaction has come back.
    wait_drained();

    // Random part: bursts with gaps; inserts are the most frequent opcode so the table holds data.
    n_random = 0;
    while (n_random < 20) begin
      stall_enable = $urandom_range(0, 3) != 0;
      burst_len = $urandom_range(1, 8);
      for (int b = 0; b < burst_len; b++) begin
        case ($urandom_range(0, 19)) inside
          [0:7]:   op = OP_INSERT;
          [8:11]:  op = OP_DELETE;
          [12:14]: op = OP_SEARCH;
          [15:16]: op = OP_SORT;
          [17:18]: op = OP_DISPLAY;
          default: op = 3'($urandom_range(5, 7));
        endcase
        send_burst_item(op, rand_value(40),
                        ($urandom_range(0, 3) == 0 || shadow_count == 0) ?
                          6'($urandom) : 6'($urandom_range(0, shadow_count - 1)),
                        b != burst_len - 1);
        n_random++;
      end
      repeat ($urandom_range(0, 12)) @(negedge clk);
    end

    wait_drained();
    $display("Covered %0d requests and %0d result transactions, including full, empty,",
             item_count, result_count);
    $display("out-of-range delete, missed search, bad opcodes and full-table sort listings.");
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("ERROR: timeout");
    $display("Mismatches found");
    $finish;
  end

endmodule

/* sim.f */
rtl/ate_pkg.sv
rtl/ate_if.sv
rtl/ate_cell.sv
rtl/array_table_engine.sv
bench/ate_tb_if.sv
bench/array_table_engine_tb.sv
